>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the kd-tree lookup RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, quiet while reset is asserted.
`define KDT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define KDT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/kdt_pkg.sv
// ----------------------------------------------------------------------------
// kdt_pkg
// Constants, node entry layout and link helpers for the kd-tree lookup.
// ----------------------------------------------------------------------------
package kdt_pkg;

  // Node memory depth and coordinate width
  localparam int NODES      = 1024;
  localparam int COORD_BITS = 16;

  // Fixed field widths
  localparam int INDEX_BITS    = 10;
  localparam int LINK_BITS     = 11;
  localparam int LINK_MAG_BITS = LINK_BITS - 1;
  localparam int REGION_BITS   = 10;

  // Derived sizes
  localparam int NODE_AW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int STEP_BITS = $clog2(NODES + 1);

  // Reciprocal used to wrap a link into the table: q = (v * RECIP) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 2 * LINK_MAG_BITS;
  localparam int RECIP       = (1 << RECIP_SHIFT) / NODES;
  localparam int RECIP_BITS  = $clog2(RECIP + 1);
  localparam int PROD_BITS   = LINK_MAG_BITS + RECIP_BITS;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_LOOP = 1'b1;

  // One node entry as held in the node memory
  typedef struct packed {
    logic                          axis;
    logic signed [COORD_BITS-1:0]  split;
    logic signed [LINK_BITS-1:0]   less;
    logic signed [LINK_BITS-1:0]   more;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // Region number of a leaf link: -(link + 1) is the complement
  function automatic logic [REGION_BITS-1:0] leaf_region(logic signed [LINK_BITS-1:0] link);
    logic [LINK_BITS-1:0] inv;
    inv = ~link;
    return inv[REGION_BITS-1:0];
  endfunction

  // Node memory address of a non-negative link already wrapped into the table
  function automatic logic [NODE_AW-1:0] link_addr(logic signed [LINK_BITS-1:0] link);
    logic [LINK_MAG_BITS-1:0] mag;
    mag = link[LINK_MAG_BITS-1:0];
    return NODE_AW'(mag);
  endfunction

endpackage

>>> hdl/kdt_in_if.sv
// ----------------------------------------------------------------------------
// kdt_in_if
// Input channel of the kd-tree lookup: node writes and point queries.
// ----------------------------------------------------------------------------
interface kdt_in_if;

  logic                                    valid;
  logic                                    ready;
  logic                                    func;
  logic        [kdt_pkg::INDEX_BITS-1:0]   node_index;
  logic                                    split_axis;
  logic signed [kdt_pkg::COORD_BITS-1:0]   split_at;
  logic signed [kdt_pkg::LINK_BITS-1:0]    less_child;
  logic signed [kdt_pkg::LINK_BITS-1:0]    more_child;
  logic signed [kdt_pkg::COORD_BITS-1:0]   point_x;
  logic signed [kdt_pkg::COORD_BITS-1:0]   point_y;

  modport source (
    output valid, func, node_index, split_axis, split_at, less_child, more_child,
           point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, func, node_index, split_axis, split_at, less_child, more_child,
           point_x, point_y,
    output ready
  );

endinterface

>>> hdl/kdt_out_if.sv
// ----------------------------------------------------------------------------
// kdt_out_if
// Result channel of the kd-tree lookup: region number and status.
// ----------------------------------------------------------------------------
interface kdt_out_if;

  logic                             valid;
  logic                             ready;
  logic [kdt_pkg::REGION_BITS-1:0]  region;
  logic                             status;

  modport source (
    output valid, region, status,
    input  ready
  );

  modport sink (
    input  valid, region, status,
    output ready
  );

endinterface

>>> hdl/kdt_ram.sv
// ----------------------------------------------------------------------------
// kdt_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module kdt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Store write data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/kd_tree_point_region_lookup.sv
// ----------------------------------------------------------------------------
// kd_tree_point_region_lookup
// Point location in a 2-D kd-tree held in a node memory.
// ----------------------------------------------------------------------------
// One transaction at a time. A node write is accepted, then the reciprocal
// multiply wraps the child links into the table, then the multiply-subtract
// runs and the entry is stored, and then the result register is loaded. A
// query issues the read of node 0 in the accepting cycle, then reads one node
// per tree level on the single read port of the node memory, then loads the
// result register. A walk that visits NODES nodes without reaching a leaf
// ends with a loop error. While the output register still holds an untaken
// result, a finished transaction waits until that result is taken. The node
// memory has no reset and no clearing pass; entries must be written before a
// query reaches them. A new transaction is accepted once the previous result
// is in the output register, whether or not it has been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kd_tree_point_region_lookup (
  input  logic   clk_i,
  input  logic   rst_ni,
  kdt_in_if.sink   in_i,
  kdt_out_if.source out_o
);

  // State codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WMOD   = 3'd1;
  localparam logic [2:0] S_WSTORE = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  // Latched transaction fields
  logic        [kdt_pkg::INDEX_BITS-1:0]    wr_idx_q;
  logic                                     axis_q;
  logic signed [kdt_pkg::COORD_BITS-1:0]    split_q;
  logic signed [kdt_pkg::LINK_BITS-1:0]     less_q;
  logic signed [kdt_pkg::LINK_BITS-1:0]     more_q;
  logic signed [kdt_pkg::COORD_BITS-1:0]    px_q;
  logic signed [kdt_pkg::COORD_BITS-1:0]    py_q;
  logic        [kdt_pkg::LINK_MAG_BITS-1:0] q_less_q, q_less_d;
  logic        [kdt_pkg::LINK_MAG_BITS-1:0] q_more_q, q_more_d;

  // Walk state and result flags
  logic signed [kdt_pkg::LINK_BITS-1:0] node_q, node_d;
  logic        [kdt_pkg::STEP_BITS-1:0] steps_q, steps_d;
  logic                                 is_write_q, is_write_d;
  logic                                 err_q, err_d;

  // Output register
  logic                            out_valid_q;
  logic [kdt_pkg::REGION_BITS-1:0] out_region_q;
  logic                            out_status_q;

  // Node memory ports
  logic                          wr_en;
  logic [kdt_pkg::NODE_AW-1:0]   wr_addr;
  kdt_pkg::node_t                wr_entry;
  logic                          rd_en;
  logic [kdt_pkg::NODE_AW-1:0]   rd_addr;
  logic [kdt_pkg::NODE_W-1:0]    rd_data;
  kdt_pkg::node_t                rd_entry;

  logic in_fire;
  logic out_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  kdt_ram #(
    .Width (kdt_pkg::NODE_W),
    .Depth (kdt_pkg::NODES)
  ) u_node_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_entry = kdt_pkg::node_t'(rd_data);

  // Wrap step one: estimate the quotient of each link magnitude by NODES
  logic [kdt_pkg::PROD_BITS-1:0] prod_less, prod_more;

  always_comb begin
    prod_less = kdt_pkg::PROD_BITS'(less_q[kdt_pkg::LINK_MAG_BITS-1:0])
              * kdt_pkg::PROD_BITS'(kdt_pkg::RECIP);
    prod_more = kdt_pkg::PROD_BITS'(more_q[kdt_pkg::LINK_MAG_BITS-1:0])
              * kdt_pkg::PROD_BITS'(kdt_pkg::RECIP);
    q_less_d  = kdt_pkg::LINK_MAG_BITS'(prod_less >> kdt_pkg::RECIP_SHIFT);
    q_more_d  = kdt_pkg::LINK_MAG_BITS'(prod_more >> kdt_pkg::RECIP_SHIFT);
  end

  // Wrap step two: subtract quotient times NODES, correct once
  logic [kdt_pkg::LINK_MAG_BITS-1:0] rem_less, rem_more;
  logic signed [kdt_pkg::LINK_BITS-1:0] less_wrap, more_wrap;

  always_comb begin
    rem_less = less_q[kdt_pkg::LINK_MAG_BITS-1:0]
             - q_less_q * kdt_pkg::LINK_MAG_BITS'(kdt_pkg::NODES);
    rem_more = more_q[kdt_pkg::LINK_MAG_BITS-1:0]
             - q_more_q * kdt_pkg::LINK_MAG_BITS'(kdt_pkg::NODES);
    if (32'(rem_less) >= kdt_pkg::NODES) begin
      rem_less = rem_less - kdt_pkg::LINK_MAG_BITS'(kdt_pkg::NODES);
    end
    if (32'(rem_more) >= kdt_pkg::NODES) begin
      rem_more = rem_more - kdt_pkg::LINK_MAG_BITS'(kdt_pkg::NODES);
    end
    // leaf links pass unchanged
    less_wrap = less_q[kdt_pkg::LINK_BITS-1] ? less_q : {1'b0, rem_less};
    more_wrap = more_q[kdt_pkg::LINK_BITS-1] ? more_q : {1'b0, rem_more};
  end

  assign wr_entry.axis  = axis_q;
  assign wr_entry.split = split_q;
  assign wr_entry.less  = less_wrap;
  assign wr_entry.more  = more_wrap;
  assign wr_addr        = kdt_pkg::NODE_AW'(wr_idx_q);

  // Walk step: compare the chosen coordinate with the split of the node read
  logic signed [kdt_pkg::COORD_BITS-1:0] coord;
  logic signed [kdt_pkg::LINK_BITS-1:0]  next_link;
  logic        [kdt_pkg::STEP_BITS-1:0]  steps_inc;

  always_comb begin
    coord     = rd_entry.axis ? py_q : px_q;
    next_link = (coord < rd_entry.split) ? rd_entry.less : rd_entry.more;
    steps_inc = steps_q + kdt_pkg::STEP_BITS'(1);
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    node_d     = node_q;
    steps_d    = steps_q;
    is_write_d = is_write_q;
    err_d      = err_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.func == kdt_pkg::FUNC_WRITE) begin
            is_write_d = 1'b1;
            err_d      = 1'b0;
            state_d    = S_WMOD;
          end else begin
            // start the walk at node 0
            is_write_d = 1'b0;
            err_d      = 1'b0;
            node_d     = '0;
            steps_d    = '0;
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_d    = S_WALK;
          end
        end
      end
      S_WMOD: begin
        state_d = S_WSTORE;
      end
      S_WSTORE: begin
        // drop writes to slots beyond the table
        wr_en   = (32'(wr_idx_q) < kdt_pkg::NODES);
        state_d = S_DONE;
      end
      S_WALK: begin
        node_d  = next_link;
        steps_d = steps_inc;
        if (next_link[kdt_pkg::LINK_BITS-1]) begin
          state_d = S_DONE;
        end else if (steps_inc == kdt_pkg::STEP_BITS'(kdt_pkg::NODES)) begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = kdt_pkg::link_addr(next_link);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      node_q     <= '0;
      steps_q    <= '0;
      is_write_q <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      node_q     <= node_d;
      steps_q    <= steps_d;
      is_write_q <= is_write_d;
      err_q      <= err_d;
    end
  end

  // Capture transaction payload and quotient estimates
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      wr_idx_q <= in_i.node_index;
      axis_q   <= in_i.split_axis;
      split_q  <= in_i.split_at;
      less_q   <= in_i.less_child;
      more_q   <= in_i.more_child;
      px_q     <= in_i.point_x;
      py_q     <= in_i.point_y;
    end
    if (state_q == S_WMOD) begin
      q_less_q <= q_less_d;
      q_more_q <= q_more_d;
    end
  end

  // Output register: load on completion, hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_region_q <= (is_write_q || err_q) ? '0 : kdt_pkg::leaf_region(node_q);
      out_status_q <= err_q ? kdt_pkg::STATUS_LOOP : kdt_pkg::STATUS_OK;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.region = out_region_q;
  assign out_o.status = out_status_q;

  // Assertions
  `KDT_ASSERT(a_steps_bound, clk_i, rst_ni,
              (state_q == S_WALK) |-> (32'(steps_q) < kdt_pkg::NODES),
              "walk step count reached the node limit inside the walk")
  `KDT_ASSERT(a_walk_read, clk_i, rst_ni,
              (state_q == S_WALK) |-> $past(rd_en),
              "walk step without a node read issued the cycle before")
  `KDT_ASSERT(a_result_src, clk_i, rst_ni,
              $rose(out_valid_q) |-> ($past(state_q) == S_DONE),
              "result loaded outside the completion state")
  `KDT_ASSERT(a_loop_region, clk_i, rst_ni,
              (out_valid_q && out_status_q == kdt_pkg::STATUS_LOOP) |-> (out_region_q == '0),
              "loop error result carries a non-zero region")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the kd-tree point region lookup. A short table of
// node writes and point queries covers the coordinate extremes, leaf links at
// both ends of the region range, links into the top of the table and loop
// errors. Random trees are then built from the leaves up, so that every walk
// only visits written nodes. Each tree is probed with queries that sit on,
// just below and just above its splits, mixed with stray writes. A local model
// of the node memory predicts every result. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import kdt_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 10000000;
  localparam int TAIL_CYCLES  = 16;

  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  // One input transaction as driven onto the channel
  typedef struct packed {
    logic                         func;
    logic [INDEX_BITS-1:0]        node_index;
    logic                         split_axis;
    logic signed [COORD_BITS-1:0] split_at;
    logic signed [LINK_BITS-1:0]  less_child;
    logic signed [LINK_BITS-1:0]  more_child;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } lookup_item_t;

  // One result transaction
  typedef struct packed {
    logic [REGION_BITS-1:0] region;
    logic                   status;
  } region_result_t;

  typedef struct {
    lookup_item_t   item;
    bit             typed;
    region_result_t result;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  kdt_in_if  in_if ();
  kdt_out_if out_if ();

  kd_tree_point_region_lookup u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow of the node memory
  node_t          node_shadow [NODES];
  bit             node_written [NODES];
  int             written_slots [$];
  int             tree_slots [$];

  region_result_t pending_regions [$];
  directed_row_t  directed_plan [$];
  int             mismatch_count;
  int             transactions_sent;
  int             cycle_count;
  logic           calm;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Walk the shadow tree from node 0 and return the region or a loop error
  function automatic region_result_t locate_region(
      input logic signed [COORD_BITS-1:0] px, input logic signed [COORD_BITS-1:0] py);
    region_result_t               res;
    node_t                        entry;
    logic signed [COORD_BITS-1:0] coord;
    logic signed [COORD_BITS-1:0] split_val;
    logic signed [LINK_BITS-1:0]  link;
    int                           cur;
    int                           steps;
    res.region = '0;
    res.status = STATUS_LOOP;
    cur = 0;
    for (steps = 0; steps < NODES; steps++) begin
      entry     = node_shadow[cur];
      split_val = entry.split;
      coord     = entry.axis ? py : px;
      link      = (coord < split_val) ? entry.less : entry.more;
      if (link < 0) begin
        res.region = REGION_BITS'(-(int'(link) + 1));
        res.status = STATUS_OK;
        return res;
      end
      cur = int'(link) % NODES;
    end
    return res;
  endfunction

  // Apply one accepted transaction to the shadow state and give its result
  function automatic region_result_t predict_result(input lookup_item_t it);
    region_result_t res;
    res = '{region: '0, status: STATUS_OK};
    if (it.func == FUNC_WRITE) begin
      node_shadow[it.node_index] = '{it.split_axis, it.split_at, it.less_child, it.more_child};
      if (!node_written[it.node_index]) begin
        node_written[it.node_index] = 1'b1;
        written_slots.push_back(int'(it.node_index));
      end
    end else begin
      res = locate_region(it.point_x, it.point_y);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom);
  endfunction

  function automatic logic signed [LINK_BITS-1:0] rand_leaf();
    return LINK_BITS'(-int'($urandom_range(1, 1024)));
  endfunction

  // Fill every field with noise; the block ignores what the function does not use
  function automatic lookup_item_t noise_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(lookup_item_t)-1:0];
  endfunction

  // Child link of tree position k: a leaf, a deeper node, or rarely a way back
  function automatic logic signed [LINK_BITS-1:0] tree_link(input int k, input bit allow_cycle);
    int r;
    int slot;
    r = int'($urandom_range(0, 9));
    if (allow_cycle && r == 0) begin
      slot = tree_slots[$urandom_range(0, k)];
      if (!node_written[slot]) slot = tree_slots[k];
      return LINK_BITS'(slot);
    end
    if (k == tree_slots.size() - 1 || r < 4) return rand_leaf();
    return LINK_BITS'(tree_slots[$urandom_range(k + 1, tree_slots.size() - 1)]);
  endfunction

  // Query on, beside or far from a split of the current tree
  function automatic lookup_item_t random_query();
    lookup_item_t                 it;
    node_t                        entry;
    logic signed [COORD_BITS-1:0] split_val;
    logic signed [COORD_BITS-1:0] near;
    int                           r;
    int                           slot;
    it      = noise_item();
    it.func = FUNC_QUERY;
    r       = int'($urandom_range(0, 99));
    if (r < 55 && tree_slots.size() > 0) begin
      // aim only at splits already held in the memory
      slot = tree_slots[$urandom_range(0, tree_slots.size() - 1)];
      if (!node_written[slot]) slot = 0;
      entry     = node_shadow[slot];
      split_val = entry.split;
      near      = COORD_BITS'(int'(split_val) + int'($urandom_range(0, 2)) - 1);
      if (entry.axis) it.point_y = near;
      else it.point_x = near;
    end else if (r < 65) begin
      it.point_x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      it.point_y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    end
    return it;
  endfunction

  // Stray write anywhere; links stay on written nodes, itself, or leaves
  function automatic lookup_item_t noise_write();
    lookup_item_t it;
    it      = noise_item();
    it.func = FUNC_WRITE;
    if ($urandom_range(0, 1)) it.less_child = rand_leaf();
    else it.less_child = LINK_BITS'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    if ($urandom_range(0, 3) == 0) it.more_child = LINK_BITS'(it.node_index);
    else it.more_child = rand_leaf();
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------

  // Drive one transaction, wait for its acceptance, then queue its result
  task automatic drive_item(input lookup_item_t it, input bit typed,
                            input region_result_t typed_res);
    region_result_t res;
    int             gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= it.func;
    in_if.node_index <= it.node_index;
    in_if.split_axis <= it.split_axis;
    in_if.split_at   <= it.split_at;
    in_if.less_child <= it.less_child;
    in_if.more_child <= it.more_child;
    in_if.point_x    <= it.point_x;
    in_if.point_y    <= it.point_y;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = predict_result(it);
    pending_regions.push_back(typed ? typed_res : res);
    transactions_sent++;
  endtask

  // Hold the source until every queued result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_regions.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input logic func, input int idx, input int axis, input int split,
                         input int less, input int more, input int px, input int py,
                         input bit typed, input int region, input logic status);
    directed_row_t row;
    row.item.func       = func;
    row.item.node_index = INDEX_BITS'(idx);
    row.item.split_axis = 1'(axis);
    row.item.split_at   = COORD_BITS'(split);
    row.item.less_child = LINK_BITS'(less);
    row.item.more_child = LINK_BITS'(more);
    row.item.point_x    = COORD_BITS'(px);
    row.item.point_y    = COORD_BITS'(py);
    row.typed           = typed;
    row.result          = '{region: REGION_BITS'(region), status: status};
    directed_plan.push_back(row);
  endtask

  // Build a tree bottom-up over random slots, node 0 last; sometimes cut short
  task automatic build_tree(input bit allow_cycle);
    bit           taken [NODES];
    lookup_item_t it;
    int           count;
    int           stop;
    int           k;
    int           slot;
    count = ($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 60))
                                        : int'($urandom_range(2, 16));
    tree_slots.delete();
    tree_slots.push_back(0);
    taken[0] = 1'b1;
    while (tree_slots.size() < count) begin
      slot = int'($urandom_range(1, NODES - 1));
      if (!taken[slot]) begin
        taken[slot] = 1'b1;
        tree_slots.push_back(slot);
      end
    end
    stop = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, count - 1)) : 0;
    for (k = count - 1; k >= stop; k--) begin
      it            = noise_item();
      it.func       = FUNC_WRITE;
      it.node_index = INDEX_BITS'(tree_slots[k]);
      it.less_child = tree_link(k, allow_cycle);
      it.more_child = tree_link(k, allow_cycle);
      drive_item(it, 1'b0, '0);
      if ($urandom_range(0, 9) == 0) drive_item(random_query(), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sink side and checking
  // --------------------------------------------------------------------------

  task automatic check_result();
    region_result_t want;
    if (pending_regions.size() == 0) begin
      $error("result with nothing pending: region %0d, status %0d",
             out_if.region, out_if.status);
      mismatch_count++;
    end else begin
      want = pending_regions.pop_front();
      if (out_if.region !== want.region) begin
        $error("region: expected %0d, got %0d", want.region, out_if.region);
        mismatch_count++;
      end
      if (out_if.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_if.status);
        mismatch_count++;
      end
    end
  endtask

  // Take results, stalling at random
  initial begin : result_sink
    int hold;
    out_if.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_result();
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        hold = pick_gap();
        out_if.ready <= (hold == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Clock, calm stretches and watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Alternate stretches with and without idling
  initial begin
    calm <= 1'b0;
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk_i);
      calm <= ~calm;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin : stimulus
    int tree_count;
    int burst;
    int q;
    mismatch_count    = 0;
    transactions_sent = 0;
    rst_ni            = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.func       <= FUNC_WRITE;
    in_if.node_index <= '0;
    in_if.split_axis <= 1'b0;
    in_if.split_at   <= '0;
    in_if.less_child <= '0;
    in_if.more_child <= '0;
    in_if.point_x    <= '0;
    in_if.point_y    <= '0;

    // Leaves at both ends of the region range, split at zero
    add_row(FUNC_WRITE, 0, 0, 0, -1, -1024, 0, 0, 1, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, -1, 0, 1, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 1023, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, -32768, 32767, 1, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, 32767, -32768, 1, 1023, STATUS_OK);
    // Two levels: top slot of the table and a y split at the minimum
    add_row(FUNC_WRITE, 1023, 0, 32767, -2, -3, 0, 0, 1, 0, STATUS_OK);
    add_row(FUNC_WRITE, 512, 1, -32768, -1024, -512, 0, 0, 1, 0, STATUS_OK);
    add_row(FUNC_WRITE, 0, 1, 0, 512, 1023, 0, 0, 1, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, 32767, 0, 0, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, 32766, 32767, 0, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, -32768, -32768, 0, 0, STATUS_OK);
    // A node that links to itself: loop error on one side only
    add_row(FUNC_WRITE, 1, 0, -32768, -7, 1, 0, 0, 1, 0, STATUS_OK);
    add_row(FUNC_WRITE, 0, 0, 100, 1, -9, 0, 0, 1, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, 99, 0, 1, 0, STATUS_LOOP);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, 100, 0, 1, 8, STATUS_OK);
    add_row(FUNC_WRITE, 1, 0, 5, -7, 1, 0, 0, 1, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, 4, -5, 0, 0, STATUS_OK);
    add_row(FUNC_QUERY, 0, 0, 0, 0, 0, 5, 5, 1, 0, STATUS_LOOP);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_plan[i]) begin
      drive_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].result);
    end

    // Random trees, each probed by a burst of queries and stray writes
    transactions_sent = 0;
    tree_count        = 0;
    while (transactions_sent < RANDOM_ITEMS) begin
      drain_results();
      build_tree(tree_count == 2 || $urandom_range(0, 15) == 0);
      tree_count++;
      burst = int'($urandom_range(8, 40));
      for (q = 0; q < burst; q++) begin
        if ($urandom_range(0, 99) < 85) drive_item(random_query(), 1'b0, '0);
        else drive_item(noise_write(), 1'b0, '0);
      end
    end

    // Let the last results arrive, then a short tail for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
